### rtl/core/olq_pkg.sv
`default_nettype none
package olq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PTR_W      = CNT_W + 1;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_SEARCH = 3'd1,
    OP_DELETE = 3'd2,
    OP_POP    = 3'd3,
    OP_PEEK   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage
`default_nettype wire

### rtl/core/ordered_list_queue.sv
// Ordered list queue: a bounded list of up to 16 signed 32-bit values kept in
// insertion order, held packed from the front in a single-port-read,
// single-port-write synchronous memory.
// A request is taken at a rising edge where start is high and busy is low;
// op selects append, search, delete key, pop front, peek front or clear, and
// value carries the datum or the key. Each request gives exactly one result,
// shown on status, data, position and count for one cycle while done is high.
// The receiver cannot stall, so results must be taken as they appear.
// Append, clear, unknown codes and requests on an empty list finish in the idle
// state, without a scan. Search and peek read the memory one entry per cycle
// through its registered read port; a search that fails ends at the last entry.
// Delete and pop then close up the later entries, one read and one write per
// cycle; the memory's single read port sets this pace. busy stays high until
// the result is shown, and a new request can be taken in the cycle that done
// is high.
// A synchronous reset empties the list; the memory contents are not cleared,
// as only entries below the count are ever used.
`default_nettype none
module ordered_list_queue (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [2:0]                          op,
  input  wire logic signed [olq_pkg::DATA_WIDTH-1:0] value,
  output logic                                     done,
  output logic [1:0]                               status,
  output logic signed [olq_pkg::DATA_WIDTH-1:0]    data,
  output logic [olq_pkg::ADDR_W-1:0]               position,
  output logic [olq_pkg::CNT_W-1:0]                count
);

  logic [olq_pkg::DATA_WIDTH-1:0] mem [olq_pkg::CAPACITY];

  olq_pkg::state_t                state;
  olq_pkg::state_t                state_next;
  logic [2:0]                     cur_op;
  logic [olq_pkg::DATA_WIDTH-1:0] key;
  logic [olq_pkg::CNT_W-1:0]      fill;
  logic [olq_pkg::CNT_W-1:0]      fill_next;
  logic [olq_pkg::ADDR_W-1:0]     scan_idx;
  logic [olq_pkg::ADDR_W-1:0]     pend_idx;
  logic [olq_pkg::DATA_WIDTH-1:0] rd_data;
  logic [olq_pkg::PTR_W-1:0]      sh_rd;
  logic [olq_pkg::ADDR_W-1:0]     sh_wr;
  logic                           sh_pend;
  logic [olq_pkg::DATA_WIDTH-1:0] hold_data;
  logic [olq_pkg::ADDR_W-1:0]     hold_pos;

  logic [olq_pkg::ADDR_W-1:0]     rd_addr;
  logic                           wr_en;
  logic [olq_pkg::ADDR_W-1:0]     wr_addr;
  logic [olq_pkg::DATA_WIDTH-1:0] wr_data;
  logic                           finish;
  logic [1:0]                     res_status;
  logic [olq_pkg::DATA_WIDTH-1:0] res_data;
  logic [olq_pkg::ADDR_W-1:0]     res_pos;

  logic                           front_op;
  logic                           closes;
  logic                           hit;
  logic                           last;
  logic [olq_pkg::ADDR_W-1:0]     fill_m1;
  logic [olq_pkg::PTR_W-1:0]      fill_ext;
  logic [olq_pkg::PTR_W-1:0]      pend_ext;
  logic                           list_busy_op;

  assign front_op = (cur_op == olq_pkg::OP_POP) || (cur_op == olq_pkg::OP_PEEK);
  assign closes   = (cur_op == olq_pkg::OP_DELETE) || (cur_op == olq_pkg::OP_POP);
  assign hit      = front_op || (rd_data == key);
  assign fill_m1  = olq_pkg::ADDR_W'(fill - olq_pkg::CNT_W'(1));
  assign last     = (pend_idx == fill_m1);
  assign fill_ext = olq_pkg::PTR_W'(fill);
  assign pend_ext = olq_pkg::PTR_W'(pend_idx);

  assign list_busy_op = (op == olq_pkg::OP_SEARCH) || (op == olq_pkg::OP_DELETE) ||
                        (op == olq_pkg::OP_POP) || (op == olq_pkg::OP_PEEK);

  assign busy  = (state != olq_pkg::S_IDLE);
  assign count = fill;

  always_comb begin
    state_next = state;
    unique case (state)
      olq_pkg::S_IDLE: begin
        if (start && list_busy_op && (fill != '0)) begin
          state_next = olq_pkg::S_SCAN;
        end
      end
      olq_pkg::S_SCAN: begin
        if (hit) begin
          state_next = closes ? olq_pkg::S_SHIFT : olq_pkg::S_IDLE;
        end else if (last) begin
          state_next = olq_pkg::S_IDLE;
        end
      end
      olq_pkg::S_SHIFT: begin
        if (sh_rd >= fill_ext) begin
          state_next = olq_pkg::S_IDLE;
        end
      end
      default: state_next = olq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    finish     = 1'b0;
    res_status = olq_pkg::ST_OK;
    res_data   = '0;
    res_pos    = '0;
    fill_next  = fill;
    rd_addr    = scan_idx;
    wr_en      = 1'b0;
    wr_addr    = sh_wr;
    wr_data    = rd_data;
    unique case (state)
      olq_pkg::S_IDLE: begin
        rd_addr = '0;
        if (start) begin
          case (op)
            olq_pkg::OP_APPEND: begin
              finish = 1'b1;
              if (fill >= olq_pkg::CNT_W'(olq_pkg::CAPACITY)) begin
                res_status = olq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = fill[olq_pkg::ADDR_W-1:0];
                wr_data   = value;
                fill_next = fill + olq_pkg::CNT_W'(1);
              end
            end
            olq_pkg::OP_SEARCH, olq_pkg::OP_DELETE: begin
              if (fill == '0) begin
                finish     = 1'b1;
                res_status = olq_pkg::ST_NOT_FOUND;
              end
            end
            olq_pkg::OP_POP, olq_pkg::OP_PEEK: begin
              if (fill == '0) begin
                finish     = 1'b1;
                res_status = olq_pkg::ST_EMPTY;
              end
            end
            olq_pkg::OP_CLEAR: begin
              finish    = 1'b1;
              fill_next = '0;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      olq_pkg::S_SCAN: begin
        if (hit && !closes) begin
          finish   = 1'b1;
          res_data = rd_data;
          res_pos  = pend_idx;
        end else if (!hit && last) begin
          finish     = 1'b1;
          res_status = olq_pkg::ST_NOT_FOUND;
        end
      end
      olq_pkg::S_SHIFT: begin
        rd_addr = sh_rd[olq_pkg::ADDR_W-1:0];
        wr_en   = sh_pend;
        if (sh_rd >= fill_ext) begin
          finish    = 1'b1;
          res_data  = hold_data;
          res_pos   = hold_pos;
          fill_next = fill - olq_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= olq_pkg::S_IDLE;
      fill    <= '0;
      done    <= 1'b0;
      sh_pend <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= finish;
      unique case (state)
        olq_pkg::S_IDLE: begin
          sh_pend <= 1'b0;
        end
        olq_pkg::S_SCAN: begin
          if (hit) begin
            sh_pend <= ((pend_ext + olq_pkg::PTR_W'(1)) < fill_ext);
          end
        end
        olq_pkg::S_SHIFT: begin
          sh_pend <= (sh_rd < fill_ext);
        end
        default: sh_pend <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status   <= res_status;
      data     <= res_data;
      position <= res_pos;
    end
    unique case (state)
      olq_pkg::S_IDLE: begin
        if (start) begin
          cur_op   <= op;
          key      <= value;
          scan_idx <= olq_pkg::ADDR_W'(1);
          pend_idx <= '0;
        end
      end
      olq_pkg::S_SCAN: begin
        scan_idx <= scan_idx + olq_pkg::ADDR_W'(1);
        pend_idx <= scan_idx;
        if (hit) begin
          hold_data <= rd_data;
          hold_pos  <= pend_idx;
          sh_wr     <= pend_idx;
          sh_rd     <= pend_ext + olq_pkg::PTR_W'(2);
        end
      end
      olq_pkg::S_SHIFT: begin
        sh_wr <= olq_pkg::ADDR_W'(sh_rd - olq_pkg::PTR_W'(1));
        sh_rd <= sh_rd + olq_pkg::PTR_W'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### tb/sv/ordered_list_queue_tb.sv
`timescale 1ns / 100ps

module ordered_list_queue_tb;

  typedef struct {
    olq_pkg::op_t                          opc;
    logic signed [olq_pkg::DATA_WIDTH-1:0] val;
  } request_t;

  typedef struct {
    logic [1:0]                            st;
    logic signed [olq_pkg::DATA_WIDTH-1:0] dat;
    logic [olq_pkg::ADDR_W-1:0]            pos;
    logic [olq_pkg::CNT_W-1:0]             cnt;
  } outcome_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic [2:0]                            op = olq_pkg::OP_APPEND;
  logic signed [olq_pkg::DATA_WIDTH-1:0] value = '0;
  logic                                  done;
  logic [1:0]                            status;
  logic signed [olq_pkg::DATA_WIDTH-1:0] data;
  logic [olq_pkg::ADDR_W-1:0]            position;
  logic [olq_pkg::CNT_W-1:0]             count;

  request_t                              pending_requests[$];
  outcome_t                              expected_outcomes[$];
  logic signed [olq_pkg::DATA_WIDTH-1:0] list_store[olq_pkg::CAPACITY];
  int                                    list_fill = 0;
  logic                                  taken = 1'b0;
  int                                    issued = 0;
  int                                    errors = 0;

  ordered_list_queue uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .value    (value),
    .done     (done),
    .status   (status),
    .data     (data),
    .position (position),
    .count    (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic queue_request(input olq_pkg::op_t opc,
                               input logic signed [olq_pkg::DATA_WIDTH-1:0] val);
    request_t r;
    r.opc = opc;
    r.val = val;
    pending_requests.push_back(r);
  endtask

  function automatic logic signed [olq_pkg::DATA_WIDTH-1:0] key_pool(input int unsigned k);
    case (k % 8)
      0: key_pool = 32'sh0000_0000;
      1: key_pool = -32'sd1;
      2: key_pool = 32'sh8000_0000;
      3: key_pool = 32'sh7FFF_FFFF;
      4: key_pool = 32'sd1;
      5: key_pool = 32'sh5A5A_A5A5;
      6: key_pool = 32'shA5A5_5A5A;
      default: key_pool = 32'sd42;
    endcase
  endfunction

  task automatic model_request(input logic [2:0] opc,
                               input logic signed [olq_pkg::DATA_WIDTH-1:0] val);
    outcome_t r;
    int       idx;
    r.st  = olq_pkg::ST_OK;
    r.dat = '0;
    r.pos = '0;
    idx   = list_fill;
    case (olq_pkg::op_t'(opc))
      olq_pkg::OP_APPEND: begin
        if (list_fill >= olq_pkg::CAPACITY) begin
          r.st = olq_pkg::ST_FULL;
        end else begin
          list_store[list_fill] = val;
          list_fill++;
        end
      end
      olq_pkg::OP_SEARCH, olq_pkg::OP_DELETE: begin
        for (int i = list_fill - 1; i >= 0; i--) begin
          if (list_store[i] == val) idx = i;
        end
        if (idx >= list_fill) begin
          r.st = olq_pkg::ST_NOT_FOUND;
        end else begin
          r.dat = list_store[idx];
          r.pos = idx[olq_pkg::ADDR_W-1:0];
          if (olq_pkg::op_t'(opc) == olq_pkg::OP_DELETE) begin
            for (int i = idx; i + 1 < list_fill; i++) list_store[i] = list_store[i + 1];
            list_fill--;
          end
        end
      end
      olq_pkg::OP_POP, olq_pkg::OP_PEEK: begin
        if (list_fill == 0) begin
          r.st = olq_pkg::ST_EMPTY;
        end else begin
          r.dat = list_store[0];
          if (olq_pkg::op_t'(opc) == olq_pkg::OP_POP) begin
            for (int i = 0; i + 1 < list_fill; i++) list_store[i] = list_store[i + 1];
            list_fill--;
          end
        end
      end
      olq_pkg::OP_CLEAR: list_fill = 0;
      default: ;
    endcase
    r.cnt = list_fill[olq_pkg::CNT_W-1:0];
    expected_outcomes.push_back(r);
  endtask

  // Requests change at the falling edge; a request is held until the block takes it.
  always @(negedge clk) begin
    request_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (pending_requests.size() > 0 &&
                 ((issued >= 250 && issued < 400) || $urandom_range(0, 99) >= 10)) begin
      nxt = pending_requests.pop_front();
      op    <= nxt.opc;
      value <= nxt.val;
      start <= 1'b1;
      issued++;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with none expected: status %h data %h position %h count %h",
                   $time, status, data, position, count);
          errors++;
        end else begin
          e = expected_outcomes.pop_front();
          if (status !== e.st) begin
            $display("%0t: status expected %h actual %h", $time, e.st, status);
            errors++;
          end
          if (data !== e.dat) begin
            $display("%0t: data expected %h actual %h", $time, e.dat, data);
            errors++;
          end
          if (position !== e.pos) begin
            $display("%0t: position expected %h actual %h", $time, e.pos, position);
            errors++;
          end
          if (count !== e.cnt) begin
            $display("%0t: count expected %h actual %h", $time, e.cnt, count);
            errors++;
          end
        end
      end
      if (start && !busy) model_request(op, value);
      taken <= start && !busy;
    end
  end

  initial begin
    int unsigned r;
    int unsigned append_bias;
    rst = 1'b1;

    queue_request(olq_pkg::OP_PEEK, 32'sd0);
    queue_request(olq_pkg::OP_POP, 32'sd0);
    queue_request(olq_pkg::OP_SEARCH, 32'sd0);
    queue_request(olq_pkg::OP_DELETE, -32'sd1);
    queue_request(olq_pkg::OP_APPEND, 32'sh8000_0000);
    queue_request(olq_pkg::OP_APPEND, 32'sh7FFF_FFFF);
    queue_request(olq_pkg::OP_APPEND, -32'sd1);
    queue_request(olq_pkg::OP_APPEND, 32'sh7FFF_FFFF);
    queue_request(olq_pkg::OP_SEARCH, 32'sh7FFF_FFFF);
    queue_request(olq_pkg::OP_DELETE, 32'sh7FFF_FFFF);
    queue_request(olq_pkg::OP_SEARCH, 32'sd5);
    queue_request(olq_pkg::OP_PEEK, 32'sd0);
    queue_request(olq_pkg::OP_POP, 32'sd0);
    queue_request(olq_pkg::OP_CLEAR, 32'sd0);
    for (int i = 0; i < olq_pkg::CAPACITY; i++) queue_request(olq_pkg::OP_APPEND, key_pool(i));
    queue_request(olq_pkg::OP_APPEND, 32'sd99);
    queue_request(olq_pkg::OP_SEARCH, key_pool(olq_pkg::CAPACITY - 1));
    queue_request(olq_pkg::OP_DELETE, key_pool(olq_pkg::CAPACITY - 1));
    queue_request(olq_pkg::OP_DELETE, key_pool(0));
    queue_request(olq_pkg::OP_CLEAR, 32'sd0);
    queue_request(olq_pkg::OP_SEARCH, key_pool(1));

    for (int n = 0; n < 650; n++) begin
      append_bias = ((n / 80) % 2 == 0) ? 60 : 25;
      r = $urandom_range(0, 99);
      if (r < append_bias)
        queue_request(olq_pkg::OP_APPEND, ($urandom_range(0, 3) == 0) ? $urandom() :
                                          key_pool($urandom_range(0, 7)));
      else if (r < append_bias + (100 - append_bias) * 3 / 10)
        queue_request(olq_pkg::OP_SEARCH, ($urandom_range(0, 4) == 0) ? $urandom() :
                                          key_pool($urandom_range(0, 7)));
      else if (r < append_bias + (100 - append_bias) * 6 / 10)
        queue_request(olq_pkg::OP_DELETE, ($urandom_range(0, 4) == 0) ? $urandom() :
                                          key_pool($urandom_range(0, 7)));
      else if (r < append_bias + (100 - append_bias) * 8 / 10)
        queue_request(olq_pkg::OP_POP, $urandom());
      else if (r < 98)
        queue_request(olq_pkg::OP_PEEK, $urandom());
      else
        queue_request(olq_pkg::OP_CLEAR, $urandom());
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() > 0 || start) @(posedge clk);
    while (expected_outcomes.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (expected_outcomes.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, expected_outcomes.size());
    end
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
